[hdl/pbpc_pkg.sv]
// package: widths, register indexes, phase codes and helpers of the power button press controller
`default_nettype none

package pbpc_pkg;

    localparam int unsigned TICK_W       = 24;
    localparam int unsigned STEP_W       = 4;
    localparam int unsigned CFG_IDX_W    = 2;
    localparam int unsigned IN_TDATA_W   = 8;
    localparam int unsigned OUT_TDATA_W  = 16;
    localparam int unsigned OUT_FIELDS_W = 10;

    localparam logic [STEP_W-1:0] BLINK_STEPS = STEP_W'(8);

    localparam logic [TICK_W-1:0] DEBOUNCE_RESET = TICK_W'(30);
    localparam logic [TICK_W-1:0] SHORT_RESET    = TICK_W'(300000);
    localparam logic [TICK_W-1:0] LONG_RESET     = TICK_W'(5000000);
    localparam logic [TICK_W-1:0] BLINK_RESET    = TICK_W'(150000);
    localparam logic [TICK_W-1:0] PRESS_TIMER_RESET = TICK_W'(4 * 30);

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK    = 2'd3;

    localparam logic [2:0] PHASE_CODE_RELEASE = 3'd0;
    localparam logic [2:0] PHASE_CODE_PRESS   = 3'd1;
    localparam logic [2:0] PHASE_CODE_PWRON   = 3'd2;
    localparam logic [2:0] PHASE_CODE_SHORT   = 3'd3;
    localparam logic [2:0] PHASE_CODE_LONG    = 3'd4;

    typedef enum logic [4:0] {
        PH_RELEASE = 5'b00001,
        PH_PRESS   = 5'b00010,
        PH_PWRON   = 5'b00100,
        PH_SHORT   = 5'b01000,
        PH_LONG    = 5'b10000
    } t_phase;

    // zero duration acts as one
    function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
        return (v == '0) ? TICK_W'(1) : v;
    endfunction

    // difference of two durations, one when not positive
    function automatic logic [TICK_W-1:0] gap(input logic [TICK_W-1:0] hi,
                                              input logic [TICK_W-1:0] lo);
        return (hi > lo) ? (hi - lo) : TICK_W'(1);
    endfunction

    function automatic logic [2:0] phase_code(input t_phase p);
        logic [2:0] c;
        c = PHASE_CODE_RELEASE;
        unique case (p)
            PH_RELEASE: c = PHASE_CODE_RELEASE;
            PH_PRESS:   c = PHASE_CODE_PRESS;
            PH_PWRON:   c = PHASE_CODE_PWRON;
            PH_SHORT:   c = PHASE_CODE_SHORT;
            PH_LONG:    c = PHASE_CODE_LONG;
            default:    c = PHASE_CODE_RELEASE;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

[hdl/power_button_press_controller_core.sv]
// top level: debounce, press timing, power and mode decisions and led blink of the power button
//
//  channel   | direction | handshake                   | payload
//  ----------+-----------+-----------------------------+----------------------------------
//  s_axis    | in        | s_axis_tvalid/s_axis_tready | raw_level, one item per tick
//  m_axis    | out       | m_axis_tvalid/m_axis_tready | leds, dock_on, phase, pulses, mode
//  cfg       | in        | i_cfg_we                    | i_cfg_idx, i_cfg_data (24 bit)
//
//  one item per cycle while m_axis does not stall; each item's result is registered into the output register on accept
//  the state update and result for a tick are one pass of 24 bit decrements and compares
//  s_axis_tready is high whenever the output register is empty or being drained
//  a stall on m_axis holds the result and stops intake until it is taken
//  synchronous active low reset restores the power-on state
`default_nettype none

module power_button_press_controller_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // [0] raw_level, [7:1] zero
    input  wire logic [pbpc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // [0] led_one, [1] led_two, [2] dock_on, [5:3] press_phase, [6] power_on_pulse,
    // [7] power_off_pulse, [8] mode_bit, [9] mode_toggle_pulse, [15:10] zero
    output logic [pbpc_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
    input  wire logic                                i_cfg_we,
    input  wire logic [pbpc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [pbpc_pkg::TICK_W-1:0]         i_cfg_data
);

    // configuration
    logic [pbpc_pkg::TICK_W-1:0] r_debounce_ticks, r_short_ticks, r_long_ticks, r_blink_ticks;

    // state
    pbpc_pkg::t_phase            r_phase, n_phase;
    logic                        r_power, n_power;
    logic                        r_mode, n_mode;
    logic                        r_committed, n_committed;
    logic                        r_prev_raw, n_prev_raw;
    logic                        r_pending, n_pending;
    logic [pbpc_pkg::TICK_W-1:0] r_deb_cnt, n_deb_cnt;
    logic [pbpc_pkg::TICK_W-1:0] r_press_tmr, n_press_tmr;
    logic                        r_press_armed, n_press_armed;
    logic [pbpc_pkg::STEP_W-1:0] r_blink_step, n_blink_step;
    logic [pbpc_pkg::TICK_W-1:0] r_blink_tmr, n_blink_tmr;
    logic                        r_led1, n_led1;
    logic                        r_led2, n_led2;

    // output register
    logic                                  r_out_valid;
    logic [pbpc_pkg::OUT_FIELDS_W-1:0]     r_out_fields, n_out_fields;

    logic                        accept;
    logic                        raw;
    logic                        wake;
    logic                        on_p, off_p, tog_p;
    logic [pbpc_pkg::TICK_W-1:0] deb_dec, press_dec, blink_dec;
    logic                        blink_color;
    logic [pbpc_pkg::STEP_W-1:0] blink_next;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign raw           = s_axis_tdata[0];

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(pbpc_pkg::OUT_TDATA_W - pbpc_pkg::OUT_FIELDS_W){1'b0}}, r_out_fields};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ticks <= pbpc_pkg::DEBOUNCE_RESET;
            r_short_ticks    <= pbpc_pkg::SHORT_RESET;
            r_long_ticks     <= pbpc_pkg::LONG_RESET;
            r_blink_ticks    <= pbpc_pkg::BLINK_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pbpc_pkg::CFG_DEBOUNCE: r_debounce_ticks <= i_cfg_data;
                pbpc_pkg::CFG_SHORT:    r_short_ticks    <= i_cfg_data;
                pbpc_pkg::CFG_LONG:     r_long_ticks     <= i_cfg_data;
                pbpc_pkg::CFG_BLINK:    r_blink_ticks    <= i_cfg_data;
                default:                r_blink_ticks    <= r_blink_ticks;
            endcase
        end
    end

    always_comb begin
        n_phase       = r_phase;
        n_power       = r_power;
        n_mode        = r_mode;
        n_committed   = r_committed;
        n_pending     = r_pending;
        n_deb_cnt     = r_deb_cnt;
        n_press_tmr   = r_press_tmr;
        n_press_armed = r_press_armed;
        n_blink_step  = r_blink_step;
        n_blink_tmr   = r_blink_tmr;
        n_led1        = r_led1;
        n_led2        = r_led2;
        n_prev_raw    = raw;
        wake          = 1'b0;
        on_p          = 1'b0;
        off_p         = 1'b0;
        tog_p         = 1'b0;

        deb_dec   = r_deb_cnt - pbpc_pkg::TICK_W'(1);
        press_dec = (r_press_tmr == '0) ? '0 : r_press_tmr - pbpc_pkg::TICK_W'(1);
        blink_dec = (r_blink_tmr == '0) ? '0 : r_blink_tmr - pbpc_pkg::TICK_W'(1);

        // debounce
        if (raw != r_prev_raw) begin
            n_pending = raw;
            n_deb_cnt = pbpc_pkg::at_least_one(r_debounce_ticks);
        end else if (r_deb_cnt != '0) begin
            n_deb_cnt = deb_dec;
            if (deb_dec == '0 && raw == r_pending) begin
                n_committed = raw;
                wake        = 1'b1;
            end
        end

        // press timer
        if (r_press_armed) begin
            n_press_tmr = press_dec;
            if (press_dec == '0) begin
                wake = 1'b1;
            end
        end

        // blink step
        blink_color = r_blink_step[2] ? r_mode : !r_mode;
        blink_next  = r_blink_step + pbpc_pkg::STEP_W'(1);
        if (r_blink_step < pbpc_pkg::BLINK_STEPS) begin
            n_blink_tmr = blink_dec;
            if (blink_dec == '0) begin
                if (!r_blink_step[0]) begin
                    n_led1 = 1'b1;
                    n_led2 = 1'b1;
                end else begin
                    n_led1 = !blink_color;
                    n_led2 = 1'b0;
                end
                n_blink_step = blink_next;
                n_blink_tmr  = (blink_next < pbpc_pkg::BLINK_STEPS) ?
                               pbpc_pkg::at_least_one(r_blink_ticks) : '0;
            end
        end

        // press machine
        if (wake) begin
            n_press_armed = 1'b0;
            n_press_tmr   = '0;
            unique case (r_phase)
                pbpc_pkg::PH_PRESS: begin
                    if (!n_committed) begin
                        n_phase = pbpc_pkg::PH_RELEASE;
                    end else begin
                        n_phase       = pbpc_pkg::PH_SHORT;
                        n_press_tmr   = pbpc_pkg::gap(r_long_ticks, r_short_ticks);
                        n_press_armed = 1'b1;
                        if (!r_power) begin
                            n_power = 1'b1;
                            on_p    = 1'b1;
                            n_phase = pbpc_pkg::PH_PWRON;
                        end
                    end
                end
                pbpc_pkg::PH_PWRON, pbpc_pkg::PH_SHORT: begin
                    if (!n_committed) begin
                        n_phase = pbpc_pkg::PH_RELEASE;
                        if (r_phase == pbpc_pkg::PH_SHORT) begin
                            n_power = 1'b0;
                            off_p   = 1'b1;
                        end
                    end else begin
                        // mode toggle: rails stay on and blink restarts from the first step
                        n_phase      = pbpc_pkg::PH_LONG;
                        n_mode       = !r_mode;
                        tog_p        = 1'b1;
                        n_power      = 1'b1;
                        n_led1       = 1'b1;
                        n_led2       = 1'b1;
                        n_blink_step = pbpc_pkg::STEP_W'(1);
                        n_blink_tmr  = pbpc_pkg::at_least_one(r_blink_ticks);
                    end
                end
                pbpc_pkg::PH_LONG: begin
                    if (!n_committed) begin
                        n_phase = pbpc_pkg::PH_RELEASE;
                    end
                end
                default: begin
                    n_phase = pbpc_pkg::PH_RELEASE;
                    if (n_committed) begin
                        n_phase       = pbpc_pkg::PH_PRESS;
                        n_press_tmr   = pbpc_pkg::gap(r_short_ticks, r_debounce_ticks);
                        n_press_armed = 1'b1;
                    end
                end
            endcase
        end

        n_out_fields = {tog_p, n_mode, off_p, on_p, pbpc_pkg::phase_code(n_phase),
                        n_power, n_led2, n_led1};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= pbpc_pkg::PH_RELEASE;
            r_power       <= 1'b1;
            r_mode        <= 1'b0;
            r_committed   <= 1'b0;
            r_prev_raw    <= 1'b0;
            r_pending     <= 1'b0;
            r_deb_cnt     <= '0;
            r_press_tmr   <= pbpc_pkg::PRESS_TIMER_RESET;
            r_press_armed <= 1'b1;
            r_blink_step  <= pbpc_pkg::BLINK_STEPS;
            r_blink_tmr   <= '0;
            r_led1        <= 1'b1;
            r_led2        <= 1'b0;
        end else if (accept) begin
            r_phase       <= n_phase;
            r_power       <= n_power;
            r_mode        <= n_mode;
            r_committed   <= n_committed;
            r_prev_raw    <= n_prev_raw;
            r_pending     <= n_pending;
            r_deb_cnt     <= n_deb_cnt;
            r_press_tmr   <= n_press_tmr;
            r_press_armed <= n_press_armed;
            r_blink_step  <= n_blink_step;
            r_blink_tmr   <= n_blink_tmr;
            r_led1        <= n_led1;
            r_led2        <= n_led2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_fields <= n_out_fields;
        end
    end

    // power pulses never together
    a_pulse_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_fields[6] && r_out_fields[7]))
        else $error("power on and power off pulse in one item");

    // a toggle keeps the rails on and leaves the blink just started
    a_toggle_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_fields[9]) |-> (r_out_fields[2] && !r_out_fields[6] &&
        !r_out_fields[7] && r_blink_step == pbpc_pkg::STEP_W'(1)))
        else $error("mode toggle without rails on or blink restart");

    // power off only on release out of the short phase
    a_off_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_fields[7]) |->
        (!r_out_fields[2] && r_out_fields[5:3] == pbpc_pkg::PHASE_CODE_RELEASE))
        else $error("power off pulse with rails on or phase not release");

    // blink step never passes the last step
    a_blink_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_blink_step <= pbpc_pkg::BLINK_STEPS)
        else $error("blink step out of range");

    // reported phase and mode match the state registers
    a_phase_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_fields[5:3] == pbpc_pkg::phase_code(r_phase) &&
        r_out_fields[8] == r_mode))
        else $error("result disagrees with stored state");

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// testbench of the power button press controller: directed table, then random button ticks checked by a predictor
`timescale 1ns / 1ps

module tb_top;
    import pbpc_pkg::*;

    typedef struct packed {
        logic       toggle_p;
        logic       mode_bit;
        logic       off_p;
        logic       on_p;
        logic [2:0] phase;
        logic       dock_on;
        logic       led_two;
        logic       led_one;
    } button_out_t;

    typedef enum logic {ROW_TICK, ROW_REG} row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        logic                 raw;
        logic [4:0]           reps;
        logic [CFG_IDX_W-1:0] idx;
        logic [TICK_W-1:0]    val;
        logic                 typed;
        button_out_t          want;
    } stim_row_t;

    localparam logic [1:0] LED_GREEN  = 2'd0;
    localparam logic [1:0] LED_YELLOW = 2'd1;
    localparam logic [1:0] LED_OFF    = 2'd2;

    localparam button_out_t POWER_UP_OUT = '{toggle_p: 1'b0, mode_bit: 1'b0, off_p: 1'b0,
                                             on_p: 1'b0, phase: PHASE_CODE_RELEASE,
                                             dock_on: 1'b1, led_two: 1'b0, led_one: 1'b1};

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    wire                    s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    wire                    m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    wire [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx = '0;
    logic [TICK_W-1:0]      i_cfg_data = '0;

    power_button_press_controller_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // predictor state
    logic [TICK_W-1:0] debounce_cfg = DEBOUNCE_RESET;
    logic [TICK_W-1:0] short_cfg = SHORT_RESET;
    logic [TICK_W-1:0] long_cfg = LONG_RESET;
    logic [TICK_W-1:0] blink_cfg = BLINK_RESET;
    logic [2:0]        btn_phase = PHASE_CODE_RELEASE;
    logic              rails_up = 1'b1;
    logic              mode_q = 1'b0;
    logic              level_q = 1'b0;
    logic              last_raw = 1'b0;
    logic              pend_level = 1'b0;
    logic [TICK_W-1:0] debounce_left = '0;
    logic [TICK_W-1:0] press_left = PRESS_TIMER_RESET;
    logic              press_armed = 1'b1;
    logic [STEP_W-1:0] blink_idx = BLINK_STEPS;
    logic [TICK_W-1:0] blink_left = '0;
    logic              led_a = 1'b1;
    logic              led_b = 1'b0;

    button_out_t want_q[$];
    int unsigned fail_cnt = 0;
    int unsigned ticks_sent = 0;
    bit          steady = 1'b0;

    stim_row_t dir_tab [11] = '{
        '{ROW_TICK, 1'b0, 5'd1, CFG_DEBOUNCE, 24'd0, 1'b1, POWER_UP_OUT},
        '{ROW_TICK, 1'b1, 5'd1, CFG_DEBOUNCE, 24'd0, 1'b1, POWER_UP_OUT},
        '{ROW_TICK, 1'b0, 5'd1, CFG_DEBOUNCE, 24'd0, 1'b1, POWER_UP_OUT},
        '{ROW_REG,  1'b0, 5'd0, CFG_DEBOUNCE, 24'd1, 1'b0, '0},
        '{ROW_REG,  1'b0, 5'd0, CFG_SHORT,    24'd3, 1'b0, '0},
        '{ROW_REG,  1'b0, 5'd0, CFG_LONG,     24'd5, 1'b0, '0},
        '{ROW_REG,  1'b0, 5'd0, CFG_BLINK,    24'd1, 1'b0, '0},
        // short press and release powers off
        '{ROW_TICK, 1'b1, 5'd4, CFG_DEBOUNCE, 24'd0, 1'b0, '0},
        '{ROW_TICK, 1'b0, 5'd3, CFG_DEBOUNCE, 24'd0, 1'b0, '0},
        // hold while off powers on, then goes long and toggles the mode
        '{ROW_TICK, 1'b1, 5'd8, CFG_DEBOUNCE, 24'd0, 1'b0, '0},
        '{ROW_TICK, 1'b0, 5'd3, CFG_DEBOUNCE, 24'd0, 1'b0, '0}
    };

    function automatic logic [TICK_W-1:0] one_if_zero(input logic [TICK_W-1:0] v);
        return (v != '0) ? v : TICK_W'(1);
    endfunction

    function automatic logic [TICK_W-1:0] span_or_one(input logic [TICK_W-1:0] hi,
                                                      input logic [TICK_W-1:0] lo);
        if (hi > lo) begin
            return hi - lo;
        end
        return TICK_W'(1);
    endfunction

    function automatic void show_color(input logic [1:0] c);
        if (c == LED_OFF) begin
            led_a = 1'b1;
            led_b = 1'b1;
        end else if (c == LED_GREEN) begin
            led_a = 1'b1;
            led_b = 1'b0;
        end else begin
            led_a = 1'b0;
            led_b = 1'b0;
        end
    endfunction

    function automatic void blink_next();
        logic c;
        c = blink_idx[2] ? mode_q : ~mode_q;
        show_color(blink_idx[0] ? {1'b0, c} : LED_OFF);
        blink_idx = blink_idx + STEP_W'(1);
        blink_left = (blink_idx < BLINK_STEPS) ? one_if_zero(blink_cfg) : '0;
    endfunction

    function automatic void flip_mode();
        mode_q = ~mode_q;
        blink_idx = '0;
        blink_next();
        rails_up = 1'b1;
    endfunction

    function automatic button_out_t press_tick(input logic raw);
        logic        wake;
        button_out_t r;
        wake = 1'b0;
        r = '0;
        if (raw != last_raw) begin
            pend_level = raw;
            debounce_left = one_if_zero(debounce_cfg);
        end else if (debounce_left != '0) begin
            debounce_left = debounce_left - TICK_W'(1);
            if (debounce_left == '0 && raw == pend_level) begin
                level_q = raw;
                wake = 1'b1;
            end
        end
        last_raw = raw;

        if (press_armed) begin
            if (press_left != '0) press_left = press_left - TICK_W'(1);
            if (press_left == '0) wake = 1'b1;
        end

        if (blink_idx < BLINK_STEPS) begin
            if (blink_left != '0) blink_left = blink_left - TICK_W'(1);
            if (blink_left == '0) blink_next();
        end

        if (wake) begin
            press_armed = 1'b0;
            press_left = '0;
            case (btn_phase)
                PHASE_CODE_PRESS: begin
                    if (!level_q) begin
                        btn_phase = PHASE_CODE_RELEASE;
                    end else begin
                        btn_phase = PHASE_CODE_SHORT;
                        press_left = span_or_one(long_cfg, short_cfg);
                        press_armed = 1'b1;
                        if (!rails_up) begin
                            rails_up = 1'b1;
                            r.on_p = 1'b1;
                            btn_phase = PHASE_CODE_PWRON;
                        end
                    end
                end
                PHASE_CODE_PWRON: begin
                    if (!level_q) begin
                        btn_phase = PHASE_CODE_RELEASE;
                    end else begin
                        btn_phase = PHASE_CODE_LONG;
                        flip_mode();
                        r.toggle_p = 1'b1;
                    end
                end
                PHASE_CODE_SHORT: begin
                    if (!level_q) begin
                        btn_phase = PHASE_CODE_RELEASE;
                        rails_up = 1'b0;
                        r.off_p = 1'b1;
                    end else begin
                        btn_phase = PHASE_CODE_LONG;
                        flip_mode();
                        r.toggle_p = 1'b1;
                    end
                end
                PHASE_CODE_LONG: begin
                    if (!level_q) btn_phase = PHASE_CODE_RELEASE;
                end
                default: begin
                    btn_phase = PHASE_CODE_RELEASE;
                    if (level_q) begin
                        btn_phase = PHASE_CODE_PRESS;
                        press_left = span_or_one(short_cfg, debounce_cfg);
                        press_armed = 1'b1;
                    end
                end
            endcase
        end

        r.led_one = led_a;
        r.led_two = led_b;
        r.dock_on = rails_up;
        r.phase = btn_phase;
        r.mode_bit = mode_q;
        return r;
    endfunction

    function automatic void cmp(input string name, input int unsigned w, input int unsigned g);
        if (w != g) begin
            $error("%s expected %0d got %0d", name, w, g);
            fail_cnt++;
        end
    endfunction

    always @(posedge i_clk) begin : watch_out
        button_out_t got;
        button_out_t w;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[OUT_FIELDS_W-1:0];
            if (want_q.size() == 0) begin
                $error("result with no item pending");
                fail_cnt++;
            end else begin
                w = want_q.pop_front();
                cmp("led_one", 32'(w.led_one), 32'(got.led_one));
                cmp("led_two", 32'(w.led_two), 32'(got.led_two));
                cmp("dock_on", 32'(w.dock_on), 32'(got.dock_on));
                cmp("press_phase", 32'(w.phase), 32'(got.phase));
                cmp("power_on_pulse", 32'(w.on_p), 32'(got.on_p));
                cmp("power_off_pulse", 32'(w.off_p), 32'(got.off_p));
                cmp("mode_bit", 32'(w.mode_bit), 32'(got.mode_bit));
                cmp("mode_toggle_pulse", 32'(w.toggle_p), 32'(got.toggle_p));
            end
        end
    end

    always @(posedge i_clk) begin
        m_axis_tready <= steady || ($urandom_range(0, 99) >= 22);
    end

    task automatic send_tick(input logic raw, input logic typed, input button_out_t want);
        button_out_t p;
        while (!steady && $urandom_range(0, 99) < 22) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= IN_TDATA_W'(raw);
        do @(posedge i_clk); while (!s_axis_tready);
        p = press_tick(raw);
        want_q.push_back(typed ? want : p);
        ticks_sent++;
        steady = (ticks_sent >= 150 && ticks_sent < 270);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] val);
        s_axis_tvalid <= 1'b0;
        while (want_q.size() != 0) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_DEBOUNCE: debounce_cfg = val;
            CFG_SHORT:    short_cfg = val;
            CFG_LONG:     long_cfg = val;
            default:      blink_cfg = val;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin : stimulus
        int unsigned deb, sh, lg, bl, span, len, left, n;
        logic lvl;
        lvl = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[k]) begin
            if (dir_tab[k].kind == ROW_REG) begin
                write_reg(dir_tab[k].idx, dir_tab[k].val);
            end else begin
                repeat (dir_tab[k].reps) send_tick(dir_tab[k].raw, dir_tab[k].typed,
                                                   dir_tab[k].want);
                lvl = dir_tab[k].raw;
            end
        end

        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: begin
                    deb = 2; sh = 8; lg = 20; bl = 2; n = 220;
                end
                // zero and inverted durations
                1: begin
                    deb = 0; sh = 1; lg = 0; bl = 0; n = 120;
                end
                2: begin
                    deb = 3; sh = 12; lg = 40; bl = 32'hFFFFFF; n = 80;
                end
                3: begin
                    deb = 32'hFFFFFF; sh = 32'hFFFFFF; lg = 32'hFFFFFF; bl = 1; n = 40;
                end
                default: begin
                    deb = $urandom_range(0, 5);
                    sh = $urandom_range(0, 30);
                    lg = $urandom_range(0, 80);
                    bl = $urandom_range(0, 6);
                    n = 100;
                end
            endcase
            write_reg(CFG_DEBOUNCE, TICK_W'(deb));
            write_reg(CFG_SHORT, TICK_W'(sh));
            write_reg(CFG_LONG, TICK_W'(lg));
            write_reg(CFG_BLINK, TICK_W'(bl));
            span = deb + lg + 10;
            if (span > 120) span = 120;
            left = n;
            while (left > 0) begin
                lvl = ~lvl;
                len = ($urandom_range(0, 99) < 15) ? $urandom_range(1, 3)
                                                   : $urandom_range(1, span);
                if (len > left) len = left;
                repeat (len) send_tick(lvl, 1'b0, '0);
                left -= len;
            end
        end

        s_axis_tvalid <= 1'b0;
        while (want_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
